// ===== rtl/irt_pkg.sv =====
// Package with shared constants, types and the digit character function.
`default_nettype none

package irt_pkg;

  // Longest digit string and characters packed into one result.
  localparam int MAX_DIGITS  = 64;
  localparam int CHUNK_BYTES = 8;

  // Clamp limits, at the width of the radix and min_digits ports.
  localparam logic [7:0] RADIX_MIN  = 8'd2;
  localparam logic [7:0] RADIX_MAX  = 8'd36;
  localparam logic [7:0] DIGITS_MIN = 8'd1;
  localparam logic [7:0] DIGITS_MAX = 8'd64;

  // ASCII codes.
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_MINUS   = 8'h2d;
  localparam logic [5:0] DECIMAL_BASE = 6'd10;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Digit value 0..35 to its lower-case character.
  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] c;
    if (d < DECIMAL_BASE) begin
      c = CHAR_ZERO + {2'b00, d};
    end else begin
      c = CHAR_LOWER_A + {2'b00, d} - {2'b00, DECIMAL_BASE};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_to_radix_text.sv =====
// Top level of the integer to radix text converter.
`default_nettype none

// Converts a 64-bit value to its text form in a radix of 2 to 36 (radix
// values outside that range are clamped), using the characters 0-9 and a-z.
// With signed_mode set, a negative value prints as '-' followed by its
// magnitude. Digits are padded with leading '0' up to min_digits, which is
// clamped to 1..64. The text leaves most significant character first in
// results of up to eight characters, first character in the lowest byte of
// text_chunk, unused bytes zero; chunk_bytes gives the count and last_chunk
// marks the final result of a request. The digits come from a bit-serial
// restoring divider, one quotient bit per cycle over all 64 dividend bits
// for each digit, and the characters are then packed at one per cycle,
// holding on a finished chunk while the output register is still occupied.
// One request is converted at a time; the finished result sits in an output
// register, so a new request is taken while the last result still waits.
module integer_to_radix_text (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] value,
  input  wire logic [7:0]  radix,
  input  wire logic        signed_mode,
  input  wire logic [7:0]  min_digits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      text_chunk,
  output logic [3:0]       chunk_bytes,
  output logic             last_chunk
);

  irt_pkg::state_t state;

  // Request settings held for the whole conversion.
  logic [5:0]  base;       // clamped radix
  logic [6:0]  width;      // clamped minimum digit count
  logic        neg;        // a '-' leads the text

  // Bit-serial divider: the dividend shifts out of the top of quot while
  // the quotient bits shift in at the bottom; rem stays below the radix.
  logic [63:0] quot;
  logic [5:0]  rem;
  logic [5:0]  bit_cnt;
  logic [6:0]  ndig;

  // Digits in a shift line: each new digit enters at entry 0, so after the
  // division the most significant digit sits at entry 0 and is read out by
  // shifting the other way.
  logic [5:0]  digits [irt_pkg::MAX_DIGITS];

  // Character output counters.
  logic        sign_left;
  logic [6:0]  pad_left;
  logic [6:0]  chars_left;
  logic [2:0]  byte_idx;
  logic [63:0] chunk;

  // Divider step.
  logic [6:0]  trial;
  logic        take;
  logic [5:0]  rem_next;
  logic [63:0] quot_next;
  logic [6:0]  ndig_next;
  logic [6:0]  total_digits;

  // Request clamping.
  logic [7:0]  radix_clamped;
  logic [7:0]  digits_clamped;

  // Character step.
  logic [7:0]  char_out;
  logic        last_char;
  logic        chunk_done;
  logic        out_free;
  logic        emit_step;
  logic [63:0] chunk_next;

  assign in_ready = (state == irt_pkg::ST_IDLE);

  always_comb begin
    if (radix < irt_pkg::RADIX_MIN) begin
      radix_clamped = irt_pkg::RADIX_MIN;
    end else if (radix > irt_pkg::RADIX_MAX) begin
      radix_clamped = irt_pkg::RADIX_MAX;
    end else begin
      radix_clamped = radix;
    end
    if (min_digits < irt_pkg::DIGITS_MIN) begin
      digits_clamped = irt_pkg::DIGITS_MIN;
    end else if (min_digits > irt_pkg::DIGITS_MAX) begin
      digits_clamped = irt_pkg::DIGITS_MAX;
    end else begin
      digits_clamped = min_digits;
    end
  end

  // One restoring division step per cycle.
  always_comb begin
    trial     = {rem, quot[63]};
    take      = (trial >= {1'b0, base});
    rem_next  = take ? 6'(trial - {1'b0, base}) : trial[5:0];
    quot_next = {quot[62:0], take};
    ndig_next = ndig + 7'd1;
    // Digit count after padding, valid on the last step of the last digit.
    total_digits = (ndig_next > width) ? ndig_next : width;
  end

  // Character selection: sign, then padding zeros, then stored digits.
  always_comb begin
    if (sign_left) begin
      char_out = irt_pkg::CHAR_MINUS;
    end else if (pad_left != 7'd0) begin
      char_out = irt_pkg::CHAR_ZERO;
    end else begin
      char_out = irt_pkg::digit_char(digits[0]);
    end
    last_char  = (chars_left == 7'd1);
    chunk_done = last_char || (byte_idx == 3'(irt_pkg::CHUNK_BYTES - 1));
    out_free   = !out_valid || out_ready;
    emit_step  = (state == irt_pkg::ST_EMIT) && (!chunk_done || out_free);
    chunk_next = chunk;
    for (int i = 0; i < irt_pkg::CHUNK_BYTES; i++) begin
      if (byte_idx == 3'(i)) begin
        chunk_next[i*8 +: 8] = char_out;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= irt_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A finished chunk loads the output register; otherwise an accepted
      // chunk leaves it empty.
      if (emit_step && chunk_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        irt_pkg::ST_IDLE: begin
          if (in_valid) begin
            state <= irt_pkg::ST_DIV;
          end
        end
        irt_pkg::ST_DIV: begin
          if (bit_cnt == 6'd63 && quot_next == 64'd0) begin
            state <= irt_pkg::ST_EMIT;
          end
        end
        irt_pkg::ST_EMIT: begin
          if (emit_step && chunk_done && last_char) begin
            state <= irt_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= irt_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      irt_pkg::ST_IDLE: begin
        if (in_valid) begin
          neg     <= signed_mode & value[63];
          quot    <= (signed_mode & value[63]) ? 64'(~value + 64'd1) : value;
          base    <= radix_clamped[5:0];
          width   <= digits_clamped[6:0];
          rem     <= 6'd0;
          bit_cnt <= 6'd0;
          ndig    <= 7'd0;
        end
      end
      irt_pkg::ST_DIV: begin
        quot    <= quot_next;
        bit_cnt <= bit_cnt + 6'd1;
        if (bit_cnt == 6'd63) begin
          // The remainder of this pass is the next digit up.
          rem       <= 6'd0;
          ndig      <= ndig_next;
          digits[0] <= rem_next;
          for (int i = 1; i < irt_pkg::MAX_DIGITS; i++) begin
            digits[i] <= digits[i-1];
          end
          sign_left  <= neg;
          pad_left   <= total_digits - ndig_next;
          chars_left <= total_digits + {6'd0, neg};
          byte_idx   <= 3'd0;
          chunk      <= 64'd0;
        end else begin
          rem <= rem_next;
        end
      end
      irt_pkg::ST_EMIT: begin
        if (emit_step) begin
          chars_left <= chars_left - 7'd1;
          if (sign_left) begin
            sign_left <= 1'b0;
          end else if (pad_left != 7'd0) begin
            pad_left <= pad_left - 7'd1;
          end else begin
            for (int i = 0; i < irt_pkg::MAX_DIGITS - 1; i++) begin
              digits[i] <= digits[i+1];
            end
          end
          if (chunk_done) begin
            text_chunk  <= chunk_next;
            chunk_bytes <= {1'b0, byte_idx} + 4'd1;
            last_chunk  <= last_char;
            chunk       <= 64'd0;
            byte_idx    <= 3'd0;
          end else begin
            chunk    <= chunk_next;
            byte_idx <= byte_idx + 3'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== bench/integer_to_radix_text_test.sv =====
// Self-checking testbench for the integer to radix text converter.
`default_nettype none

module integer_to_radix_text_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The longest text is a sign plus MAX_DIGITS digits.
  localparam int TEXT_MAX = irt_pkg::MAX_DIGITS + 1;

  // Digit characters packed as one literal: the first character sits in the top byte.
  localparam logic [8*36-1:0] DIGIT_SET = "0123456789abcdefghijklmnopqrstuvwxyz";

  // The slowest request is a 64-digit binary value. Even if every request
  // were that slow and every chunk waited out a long stall, the run stays far below this.
  localparam longint unsigned CYCLE_LIMIT = 64'd12_000_000;

  // Quiet time after the last expected chunk, so a stray extra chunk is still caught.
  localparam int TAIL_CYCLES = 300;

  // Length of the deliberate output back-pressure window.
  localparam int HOLD_OFF_CYCLES = 3000;

  typedef struct {
    logic [63:0] value;
    logic [7:0]  radix;
    logic        sgn;
    logic [7:0]  min_digits;
  } request_t;

  typedef struct {
    logic [63:0] text;
    logic [3:0]  count;
    logic        last;
  } chunk_t;

  // Scoreboard: turns each accepted request into its expected chunks and
  // compares the chunks that leave the block against them in order.
  class radix_text_scoreboard;
    chunk_t expected_chunks[$];
    int     errors;
    int     requests;
    int     chunks;

    function new();
      errors   = 0;
      requests = 0;
      chunks   = 0;
    endfunction

    function int pending();
      return expected_chunks.size();
    endfunction

    // Prints one line per mismatch (up to a cap, so a broken block cannot flood the log).
    task report(string what);
      if (errors < 40) begin
        $display("[%0t] ERROR: %s", $realtime, what);
      end
      errors++;
    endtask

    // Predicts the text of one accepted request.
    function void note_request(request_t req);
      logic [63:0] base;
      logic [63:0] mag;
      logic [7:0]  width;
      logic        neg;
      logic [7:0]  chars [0:TEXT_MAX-1];
      int          pos;
      int          start;
      int          n;
      int          digit;
      chunk_t      c;

      requests++;
      base  = 64'((req.radix < irt_pkg::RADIX_MIN) ? irt_pkg::RADIX_MIN :
                  (req.radix > irt_pkg::RADIX_MAX) ? irt_pkg::RADIX_MAX : req.radix);
      width = (req.min_digits < irt_pkg::DIGITS_MIN) ? irt_pkg::DIGITS_MIN :
              (req.min_digits > irt_pkg::DIGITS_MAX) ? irt_pkg::DIGITS_MAX :
              req.min_digits;
      neg   = req.sgn && req.value[63];
      mag   = neg ? (~req.value + 64'd1) : req.value;

      // Digits are built from the right-hand end, least significant first.
      pos = TEXT_MAX;
      do begin
        pos--;
        digit      = int'(mag % base);
        chars[pos] = DIGIT_SET[8*(35 - digit) +: 8];
        mag        = mag / base;
      end while (mag != 0 && pos > 1);

      while ((TEXT_MAX - pos) < int'(width) && pos > 1) begin
        pos--;
        chars[pos] = irt_pkg::CHAR_ZERO;
      end

      if (neg) begin
        pos--;
        chars[pos] = irt_pkg::CHAR_MINUS;
      end

      // Split into chunks, first character in the lowest byte.
      start = pos;
      while (start < TEXT_MAX) begin
        n      = (TEXT_MAX - start > irt_pkg::CHUNK_BYTES) ? irt_pkg::CHUNK_BYTES :
                 TEXT_MAX - start;
        c.text = '0;
        for (int i = 0; i < n; i++) begin
          c.text[8*i +: 8] = chars[start + i];
        end
        c.count = 4'(n);
        c.last  = (start + n >= TEXT_MAX);
        expected_chunks.push_back(c);
        start += n;
      end
    endfunction

    // Compares one accepted output chunk with the oldest expectation.
    task check_chunk(logic [63:0] text, logic [3:0] count, logic last);
      chunk_t want;
      chunks++;
      if (expected_chunks.size() == 0) begin
        report($sformatf("unexpected chunk %h, %0d bytes, last %0b", text, count, last));
        return;
      end
      want = expected_chunks.pop_front();
      if (text !== want.text) begin
        report($sformatf("text_chunk %h, expected %h", text, want.text));
      end
      if (count !== want.count) begin
        report($sformatf("chunk_bytes %0d, expected %0d", count, want.count));
      end
      if (last !== want.last) begin
        report($sformatf("last_chunk %0b, expected %0b", last, want.last));
      end
    endtask
  endclass

  // Clock and every block input start at known values.
  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic [63:0] value       = '0;
  logic [7:0]  radix       = '0;
  logic        signed_mode = 1'b0;
  logic [7:0]  min_digits  = '0;
  logic        out_ready   = 1'b0;

  logic        in_ready;
  logic        out_valid;
  logic [63:0] text_chunk;
  logic [3:0]  chunk_bytes;
  logic        last_chunk;

  radix_text_scoreboard sb = new();

  // When set, neither side inserts gaps, so back-to-back traffic is covered too.
  bit steady_flow = 1'b1;

  // The stimulus asks the output side for a long hold-off by writing a cycle count here.
  int hold_off_request = 0;

  longint unsigned cycle_count = 0;

  integer_to_radix_text DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .radix       (radix),
    .signed_mode (signed_mode),
    .min_digits  (min_digits),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .text_chunk  (text_chunk),
    .chunk_bytes (chunk_bytes),
    .last_chunk  (last_chunk)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // A hung block or a missing chunk ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d chunks outstanding.",
               cycle_count, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return 0;
    end else if (pick < 92) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(20, 120);
  endfunction

  // Random request. Half the values are short so the bit-serial divider stays quick;
  // some use random bit lengths and some use all 64 bits.
  function automatic request_t random_request();
    request_t r;
    logic [63:0] raw;
    int pick;
    int bits;
    int sel;

    raw  = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      bits    = $urandom_range(1, 20);
      r.value = raw & ((64'd1 << bits) - 64'd1);
    end else if (pick < 80) begin
      bits    = $urandom_range(1, 64);
      r.value = (bits == 64) ? raw : raw & ((64'd1 << bits) - 64'd1);
    end else begin
      r.value = raw;
    end

    // Signed requests often carry small negative numbers, the usual case for text output.
    r.sgn = 1'($urandom_range(0, 1));
    if (r.sgn && pick < 50 && $urandom_range(0, 1) == 1) begin
      r.value = ~r.value + 64'd1;
    end

    // Mostly legal radices, with some below and above the clamp limits.
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      r.radix = 8'($urandom_range(0, 1));
    end else if (sel == 1) begin
      r.radix = 8'($urandom_range(37, 255));
    end else begin
      r.radix = 8'($urandom_range(2, 36));
    end

    sel = $urandom_range(0, 19);
    if (sel < 12) begin
      r.min_digits = 8'($urandom_range(0, 8));
    end else if (sel < 17) begin
      r.min_digits = 8'($urandom_range(9, 64));
    end else begin
      r.min_digits = 8'($urandom_range(65, 255));
    end
    return r;
  endfunction

  // Offers one request and holds it until the block takes it. Called right after a
  // rising edge. With no gap the valid simply stays high for the next request.
  task automatic send_request(request_t r, bit allow_gaps);
    int gap;
    in_valid    <= 1'b1;
    value       <= r.value;
    radix       <= r.radix;
    signed_mode <= r.sgn;
    min_digits  <= r.min_digits;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
    gap = (allow_gaps && !steady_flow) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_random(int count, bit allow_gaps);
    repeat (count) send_request(random_request(), allow_gaps);
    in_valid <= 1'b0;
  endtask

  // Pause the input until every predicted chunk has come out.
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Output side: checks each accepted chunk and drives out_ready with random
  // stalls, or with one long hold-off when the stimulus asks for it.
  initial begin
    int stall_left;
    int hold_left;
    bit ready_next;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready) begin
        sb.check_chunk(text_chunk, chunk_bytes, last_chunk);
      end
      if (hold_off_request > 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (rst) begin
        ready_next = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (!steady_flow && $urandom_range(0, 2) == 0) begin
        stall_left = gap_len();
        ready_next = (stall_left == 0);
        if (stall_left > 0) begin
          stall_left--;
        end
      end else begin
        ready_next = 1'b1;
      end
      out_ready <= ready_next;
    end
  end

  // Stimulus: a directed set of corner cases, then random phases with and without
  // idling, and one phase where the output is blocked so the block backs up.
  initial begin
    request_t directed[$];
    request_t r;

    // Zero value with a minimum count of zero or one still prints one digit, signed or not.
    directed.push_back(request_t'{64'd0, 8'd10, 1'b0, 8'd0});
    directed.push_back(request_t'{64'd0, 8'd10, 1'b1, 8'd1});
    // All ones in binary: the full 64 digits.
    directed.push_back(request_t'{64'hFFFF_FFFF_FFFF_FFFF, 8'd2, 1'b0, 8'd0});
    // Minimum count above 64 clamps to 64.
    directed.push_back(request_t'{64'hFFFF_FFFF_FFFF_FFFF, 8'd16, 1'b0, 8'd255});
    directed.push_back(request_t'{64'd0, 8'd2, 1'b0, 8'd65});
    // Most negative signed value, in decimal and as the longest possible text.
    directed.push_back(request_t'{64'h8000_0000_0000_0000, 8'd10, 1'b1, 8'd0});
    directed.push_back(request_t'{64'h8000_0000_0000_0000, 8'd2, 1'b1, 8'd64});
    // Same bit pattern read unsigned.
    directed.push_back(request_t'{64'h8000_0000_0000_0000, 8'd10, 1'b0, 8'd0});
    // Minus one signed, and the largest positive signed value.
    directed.push_back(request_t'{64'hFFFF_FFFF_FFFF_FFFF, 8'd10, 1'b1, 8'd0});
    directed.push_back(request_t'{64'h7FFF_FFFF_FFFF_FFFF, 8'd8, 1'b1, 8'd0});
    // Highest digit character.
    directed.push_back(request_t'{64'd35, 8'd36, 1'b0, 8'd1});
    directed.push_back(request_t'{64'hFFFF_FFFF_FFFF_FFFF, 8'd36, 1'b0, 8'd0});
    // Radix clamping from below and from above.
    directed.push_back(request_t'{64'd12345, 8'd0, 1'b0, 8'd0});
    directed.push_back(request_t'{64'd12345, 8'd1, 1'b0, 8'd0});
    directed.push_back(request_t'{64'd12345, 8'd37, 1'b0, 8'd0});
    directed.push_back(request_t'{64'd12345, 8'd255, 1'b0, 8'd0});
    // Chunk boundaries: exactly eight characters, then nine.
    directed.push_back(request_t'{64'd255, 8'd16, 1'b0, 8'd8});
    directed.push_back(request_t'{64'd9, 8'd10, 1'b0, 8'd9});
    // Sign in front of zero padding.
    directed.push_back(request_t'{64'hFFFF_FFFF_FFFF_FFFB, 8'd10, 1'b1, 8'd7});
    // Full padding of a one-digit value.
    directed.push_back(request_t'{64'd1, 8'd3, 1'b0, 8'd64});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, back to back on both sides.
    steady_flow = 1'b1;
    foreach (directed[i]) begin
      send_request(directed[i], 1'b0);
    end
    in_valid <= 1'b0;
    settle();

    // Random traffic with idling on both sides.
    steady_flow = 1'b0;
    run_random(190, 1'b1);
    settle();

    // Block the output for a long stretch while short requests keep coming:
    // the result register fills, the converter finishes the next one and the
    // input must stall until the output side lets go.
    hold_off_request = HOLD_OFF_CYCLES;
    repeat (10) begin
      r.value      = 64'($urandom_range(0, 9));
      r.radix      = 8'd10;
      r.sgn        = 1'b0;
      r.min_digits = 8'($urandom_range(0, 8));
      send_request(r, 1'b0);
    end
    in_valid <= 1'b0;
    settle();

    // Random traffic with no idling at all.
    steady_flow = 1'b1;
    run_random(90, 1'b0);
    settle();

    // More random traffic with idling.
    steady_flow = 1'b0;
    run_random(170, 1'b1);
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d requests into %0d checked text chunks, covering clamped radices,",
             sb.requests, sb.chunks);
    $display("padding, signed extremes, random stalls and a long output hold-off.");
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches found.", sb.errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
